[hw/rtl/ufd_pkg.sv]
`default_nettype none
package ufd_pkg;

	// Register indexes on the configuration port
	localparam logic REG_HEADER = 1'b0;
	localparam logic REG_GAP    = 1'b1;

	localparam logic [7:0]  HEADER_RESET = 8'hFC;
	localparam logic [15:0] GAP_RESET    = 16'd100;
	localparam logic [15:0] IDLE_MAX     = 16'hFFFF;

	// Frame position codes; payload byte k sits at POS_PAYLOAD + k
	localparam logic [8:0] POS_HUNT    = 9'd0;
	localparam logic [8:0] POS_TYPE    = 9'd1;
	localparam logic [8:0] POS_LENGTH  = 9'd2;
	localparam logic [8:0] POS_CHECK   = 9'd3;
	localparam logic [8:0] POS_PAYLOAD = 9'd4;

	typedef struct packed {
		logic [7:0]  header_byte;
		logic [15:0] gap_limit;
	} ufd_cfg_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic [6:0] frame_kind;
		logic       ack_wanted;
		logic       frame_end;
		logic       frame_good;
	} ufd_result_t;

endpackage
`default_nettype wire

[hw/rtl/ufd_regs.sv]
`default_nettype none
module ufd_regs (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [2:0]          paddr,
	input  wire  [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output ufd_pkg::ufd_cfg_t   cfg
);
	import ufd_pkg::*;

	logic [7:0]  header_q;
	logic [15:0] gap_q;
	logic        wr_en;
	logic        reg_sel;

	assign reg_sel = paddr[2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			gap_q    <= GAP_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_HEADER: header_q <= pwdata[7:0];
				REG_GAP:    gap_q    <= pwdata[15:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_HEADER: prdata = {24'd0, header_q};
			REG_GAP:    prdata = {16'd0, gap_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign cfg.header_byte = header_q;
	assign cfg.gap_limit   = gap_q;

endmodule
`default_nettype wire

[hw/rtl/ufd_core.sv]
`default_nettype none
module ufd_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  ufd_pkg::ufd_cfg_t     cfg,
	input  wire                   item_kind,
	input  wire  [7:0]            item_byte,
	input  wire                   advance,
	output logic                  produces,
	output ufd_pkg::ufd_result_t  result
);
	import ufd_pkg::*;

	logic [8:0]  pos_q;
	logic [7:0]  len_q;
	logic [7:0]  type_q;
	logic [7:0]  check_q;
	logic [7:0]  sum_q;
	logic [15:0] idle_q;

	logic [8:0]  pos_eff;
	logic [8:0]  pos_next;
	logic [7:0]  sum_add;
	logic [7:0]  idx;
	logic        last;
	logic        is_byte;
	logic        in_payload;

	assign is_byte    = ~item_kind;
	assign pos_eff    = (idle_q > cfg.gap_limit) ? POS_HUNT : pos_q;
	assign in_payload = pos_eff >= POS_PAYLOAD;
	assign idx        = 8'(pos_eff - POS_PAYLOAD);
	assign last       = ({1'b0, idx} + 9'd1) >= {1'b0, len_q};
	assign sum_add    = sum_q + item_byte;

	assign produces = is_byte & (in_payload | ((pos_eff == POS_CHECK) & (len_q == 8'd0)));

	always_comb begin
		result.frame_kind = type_q[6:0];
		result.ack_wanted = type_q[7];
		if (in_payload) begin
			result.has_byte     = 1'b1;
			result.payload_byte = item_byte;
			result.byte_index   = idx;
			result.frame_end    = last;
			result.frame_good   = last & (sum_add == check_q);
		end else begin
			// empty frame: the check byte closes it
			result.has_byte     = 1'b0;
			result.payload_byte = 8'd0;
			result.byte_index   = 8'd0;
			result.frame_end    = 1'b1;
			result.frame_good   = (item_byte == 8'd0);
		end
	end

	always_comb begin
		case (pos_eff)
			POS_HUNT:   pos_next = (item_byte == cfg.header_byte) ? POS_TYPE : POS_HUNT;
			POS_TYPE:   pos_next = POS_LENGTH;
			POS_LENGTH: pos_next = POS_CHECK;
			POS_CHECK:  pos_next = (len_q == 8'd0) ? POS_HUNT : POS_PAYLOAD;
			default:    pos_next = last ? POS_HUNT : pos_eff + 9'd1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_HUNT;
			len_q   <= 8'd0;
			type_q  <= 8'd0;
			check_q <= 8'd0;
			sum_q   <= 8'd0;
			idle_q  <= 16'd0;
		end else if (advance) begin
			if (!is_byte) begin
				if (idle_q != IDLE_MAX)
					idle_q <= idle_q + 16'd1;
			end else begin
				idle_q <= 16'd0;
				pos_q  <= pos_next;
				case (pos_eff)
					POS_HUNT:   ;
					POS_TYPE:   type_q <= item_byte;
					POS_LENGTH: len_q  <= item_byte;
					POS_CHECK: begin
						check_q <= item_byte;
						sum_q   <= 8'd0;
					end
					default:    sum_q  <= sum_add;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/uart_frame_deframer_checksum_unit.sv]
`default_nettype none
// Channel  | handshake          | payload
// ---------+--------------------+-------------------------------------------------
// input    | in_valid, in_stall | kind, byte_value
// output   | out_valid,out_stall| has_byte, payload_byte, byte_index, frame_kind,
//          |                    | ack_wanted, frame_end, frame_good
// config   | APB psel/penable   | paddr, pwdata, prdata (header_byte, gap_limit)
//
// One transaction per cycle sustained unless a result waits on a stalled output.
// A transaction is held in the input register, where the deframer logic updates
// frame state and, where a result is due, loads the output register.
// Reset clears frame state and loads the register defaults. A stalled output
// holds back only transactions that make a result; ticks and header bytes
// still flow past a waiting result.
module uart_frame_deframer_checksum_unit (
	input  wire         clk,
	input  wire         arst_n,
	// input channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         kind,
	input  wire  [7:0]  byte_value,
	// output channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic        has_byte,
	output logic [7:0]  payload_byte,
	output logic [7:0]  byte_index,
	output logic [6:0]  frame_kind,
	output logic        ack_wanted,
	output logic        frame_end,
	output logic        frame_good,
	// configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ufd_pkg::*;

	ufd_cfg_t    cfg;
	ufd_result_t res_comb;
	ufd_result_t res_q;

	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	logic        produces;
	logic        go_s1;
	logic        in_take;
	logic        out_free;

	ufd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// output register can take a new result if empty or being drained
	assign out_free = ~out_valid_q | ~out_stall;
	// input stage moves on unless it owes a result that cannot be placed
	assign go_s1    = valid_s1 & (~produces | out_free);
	assign in_stall = valid_s1 & ~go_s1;
	assign in_take  = in_valid & ~in_stall;

	ufd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item_kind (kind_s1),
		.item_byte (byte_s1),
		.advance   (go_s1),
		.produces  (produces),
		.result    (res_comb)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1 <= kind;
			byte_s1 <= byte_value;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && produces) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && produces)
			res_q <= res_comb;
	end

	assign out_valid    = out_valid_q;
	assign has_byte     = res_q.has_byte;
	assign payload_byte = res_q.payload_byte;
	assign byte_index   = res_q.byte_index;
	assign frame_kind   = res_q.frame_kind;
	assign ack_wanted   = res_q.ack_wanted;
	assign frame_end    = res_q.frame_end;
	assign frame_good   = res_q.frame_good;

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

// Shadow of the deframer: tracks frame position and header fields, queues the
// result each accepted transaction should produce, checks results in order.
class deframe_scoreboard;
	logic [7:0]  header_byte;
	logic [15:0] gap_limit;
	logic [8:0]  position;
	logic [7:0]  frame_len;
	logic [7:0]  type_byte;
	logic [7:0]  check_byte;
	logic [7:0]  payload_total;
	logic [15:0] idle_ticks;
	ufd_pkg::ufd_result_t pending_results[$];
	int unsigned failures;

	function new();
		header_byte   = ufd_pkg::HEADER_RESET;
		gap_limit     = ufd_pkg::GAP_RESET;
		position      = ufd_pkg::POS_HUNT;
		frame_len     = '0;
		type_byte     = '0;
		check_byte    = '0;
		payload_total = '0;
		idle_ticks    = '0;
		failures      = 0;
	endfunction

	function void set_register(logic idx, logic [15:0] value);
		if (idx == ufd_pkg::REG_HEADER) begin
			header_byte = value[7:0];
		end else begin
			gap_limit = value;
		end
	endfunction

	function void note_transaction(logic is_tick, logic [7:0] b);
		ufd_pkg::ufd_result_t res;
		logic [7:0] idx;
		if (is_tick) begin
			if (idle_ticks != ufd_pkg::IDLE_MAX)
				idle_ticks++;
			return;
		end
		if (idle_ticks > gap_limit)
			position = ufd_pkg::POS_HUNT;
		idle_ticks = '0;
		res = '0;
		res.frame_kind = type_byte[6:0];
		res.ack_wanted = type_byte[7];
		case (position)
			ufd_pkg::POS_HUNT: begin
				if (b == header_byte)
					position = ufd_pkg::POS_TYPE;
			end
			ufd_pkg::POS_TYPE: begin
				type_byte = b;
				position  = ufd_pkg::POS_LENGTH;
			end
			ufd_pkg::POS_LENGTH: begin
				frame_len = b;
				position  = ufd_pkg::POS_CHECK;
			end
			ufd_pkg::POS_CHECK: begin
				check_byte    = b;
				payload_total = '0;
				if (frame_len == 0) begin
					// empty payload: the check byte closes the frame
					position       = ufd_pkg::POS_HUNT;
					res.frame_end  = 1'b1;
					res.frame_good = (b == 8'h00);
					pending_results.push_back(res);
				end else begin
					position = ufd_pkg::POS_PAYLOAD;
				end
			end
			default: begin
				idx              = 8'(position - ufd_pkg::POS_PAYLOAD);
				payload_total    = payload_total + b;
				res.has_byte     = 1'b1;
				res.payload_byte = b;
				res.byte_index   = idx;
				if (int'(idx) + 1 >= int'(frame_len)) begin
					res.frame_end  = 1'b1;
					res.frame_good = (payload_total == check_byte);
					position       = ufd_pkg::POS_HUNT;
				end else begin
					position = position + 9'd1;
				end
				pending_results.push_back(res);
			end
		endcase
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endfunction

	function void check_result(ufd_pkg::ufd_result_t got);
		ufd_pkg::ufd_result_t want;
		if (pending_results.size() == 0) begin
			$error("result transaction with nothing pending");
			failures++;
			return;
		end
		want = pending_results.pop_front();
		compare_field("has_byte", 32'(want.has_byte), 32'(got.has_byte));
		compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
		compare_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
		compare_field("frame_kind", 32'(want.frame_kind), 32'(got.frame_kind));
		compare_field("ack_wanted", 32'(want.ack_wanted), 32'(got.ack_wanted));
		compare_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
		compare_field("frame_good", 32'(want.frame_good), 32'(got.frame_good));
	endfunction
endclass

module tb_top;
	import ufd_pkg::*;

	// Settle time before a register write: a transaction passes through the input
	// register, and a result through the output register, so this wait covers
	// anything still in flight that makes no result.
	localparam int SETTLE_CYCLES = 6;
	// Receiver hold-off, long enough for the pipe to fill and stall the input
	localparam int HOLD_CYCLES   = 400;
	// One more than the modest gap limit used in the idle gap checks
	localparam int TICK_BURST    = 31;
	// Watchdog limit, well above the worst case (every gap and stall long)
	localparam int LIMIT_NS      = 8_000_000;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef logic [7:0] byte_list_t[$];

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic        kind       = KIND_BYTE;
	logic [7:0]  byte_value = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic        has_byte;
	logic [7:0]  payload_byte;
	logic [7:0]  byte_index;
	logic [6:0]  frame_kind;
	logic        ack_wanted;
	logic        frame_end;
	logic        frame_good;
	logic        psel       = 1'b0;
	logic        penable    = 1'b0;
	logic        pwrite     = 1'b0;
	logic [2:0]  paddr      = '0;
	logic [31:0] pwdata     = '0;
	logic [31:0] prdata;
	logic        pready;

	deframe_scoreboard frames = new();
	ufd_result_t       seen_result;

	// Idling modes, set per phase by the stimulus; quiet means no gaps/stalls
	bit          sender_quiet   = 1'b0;
	bit          receiver_quiet = 1'b0;
	// Bumped by the stimulus to ask the receiver for one long hold-off
	int          holds_requested = 0;
	int unsigned transactions_sent = 0;

	uart_frame_deframer_checksum_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	initial begin
		#(LIMIT_NS);
		$display("Test completed with failures");
		$finish;
	end

	// Mostly back-to-back, some short gaps, the odd long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// Monitor: both channels sampled at the rising edge on pre-edge values.
	// The result is checked before the input is noted; with the input and result
	// registers between them they never belong to the same transaction anyway.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen_result = {has_byte, payload_byte, byte_index, frame_kind,
					ack_wanted, frame_end, frame_good};
				frames.check_result(seen_result);
			end
			if (in_valid && !in_stall)
				frames.note_transaction(kind, byte_value);
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stall runs, quiet stretches, and one long hold-off on
	// request, timed here in cycles while the sender keeps offering.
	// ------------------------------------------------------------------
	initial begin : receiver
		int run;
		int holds_done;
		holds_done = 0;
		forever begin
			if (holds_requested != holds_done) begin
				holds_done++;
				out_stall <= 1'b1;
				run = HOLD_CYCLES;
			end else if (receiver_quiet) begin
				out_stall <= 1'b0;
				run = 1;
			end else if ($urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				run = pick_gap() + 1;
			end else begin
				out_stall <= 1'b0;
				run = $urandom_range(1, 6);
			end
			repeat (run) @(posedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Sender. Every task starts and ends on a rising edge. Valid stays high
	// between back-to-back transactions rather than dropping and rising in
	// the same step; settle() is what finally lowers it.
	// ------------------------------------------------------------------
	task automatic send_item(input logic is_tick, input logic [7:0] b);
		int gap;
		gap = sender_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= is_tick;
		byte_value <= b;
		do @(posedge clk); while (in_stall);
		transactions_sent++;
	endtask

	task automatic send_bytes(input byte_list_t seq);
		foreach (seq[i])
			send_item(KIND_BYTE, seq[i]);
	endtask

	// Ticks ahead of a byte: usually none, sometimes a few, and with small
	// gap limits occasionally right around the limit to hit the timeout edge
	task automatic send_ticks();
		int roll;
		int count;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			count = 0;
		else if (roll < 96 || frames.gap_limit > 64)
			count = $urandom_range(1, 3);
		else
			count = int'(frames.gap_limit) + $urandom_range(0, 2) - 1;
		repeat (count) send_item(KIND_TICK, 8'($urandom));
	endtask

	// One frame with random content; fixed_len < 0 picks a mostly small
	// length and now and then cuts the frame short
	task automatic send_frame(input int fixed_len, input int longest);
		int         len;
		int         roll;
		int         keep;
		logic [7:0] b;
		logic [7:0] total;
		logic [7:0] check;
		byte_list_t body;
		byte_list_t frame;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_item(KIND_BYTE, 8'($urandom));
		if (fixed_len >= 0) begin
			len = fixed_len;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 80)
				len = $urandom_range(0, 6);
			else if (roll < 97)
				len = $urandom_range(7, 24);
			else
				len = $urandom_range(25, longest);
		end
		total = '0;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			body.push_back(b);
			total = total + b;
		end
		check = ($urandom_range(0, 3) != 0) ? total : 8'($urandom);
		frame = {frames.header_byte, 8'($urandom), 8'(len), check};
		foreach (body[i])
			frame.push_back(body[i]);
		if (fixed_len < 0 && $urandom_range(0, 9) == 0) begin
			keep = $urandom_range(1, frame.size());
			while (frame.size() > keep)
				void'(frame.pop_back());
		end
		foreach (frame[i]) begin
			send_ticks();
			send_item(KIND_BYTE, frame[i]);
		end
	endtask

	task automatic random_phase(input int count, input int longest,
			input bit quiet_send, input bit quiet_recv);
		int unsigned stop_at;
		stop_at        = transactions_sent + count;
		sender_quiet   = quiet_send;
		receiver_quiet = quiet_recv;
		while (transactions_sent < stop_at) begin
			if ($urandom_range(0, 9) < 8)
				send_frame(-1, longest);
			else
				send_item(1'($urandom_range(0, 1)), 8'($urandom));
		end
		sender_quiet   = 1'b0;
		receiver_quiet = 1'b0;
	endtask

	// Drop valid, let the monitor note the last accept, wait for every
	// pending result, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frames.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// APB: setup then access, done on the edge with pready high. The task then
	// waits idle with psel low, so psel is never dropped and raised in one step.
	// ------------------------------------------------------------------
	task automatic apb_cycle(input logic idx, input logic write, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input logic idx);
		logic [31:0] rdata;
		apb_cycle(idx, 1'b0, '0, rdata);
		if (idx == REG_HEADER)
			frames.compare_field("header_byte", 32'(frames.header_byte), rdata);
		else
			frames.compare_field("gap_limit", 32'(frames.gap_limit), rdata);
	endtask

	task automatic program_register(input logic idx, input logic [15:0] value);
		logic [31:0] rdata;
		apb_cycle(idx, 1'b1, 32'(value), rdata);
		frames.set_register(idx, value);
		check_register(idx);
	endtask

	task automatic configure(input logic [7:0] header, input logic [15:0] gap);
		settle();
		program_register(REG_HEADER, 16'(header));
		program_register(REG_GAP, gap);
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults after reset
		check_register(REG_HEADER);
		check_register(REG_GAP);

		// Directed, default header and gap limit:
		// noise, then empty frame with good check, ack bit and kind 7F
		send_bytes('{8'h00, HEADER_RESET, 8'hFF, 8'h00, 8'h00});
		// empty frame, bad check
		send_bytes('{HEADER_RESET, 8'h00, 8'h00, 8'h01});
		// tick carrying a byte value that must be ignored
		send_item(KIND_TICK, 8'hA5);
		// payload sum wraps to zero, good
		send_bytes('{HEADER_RESET, 8'h85, 8'h02, 8'h00, 8'hFF, 8'h01});
		// single payload byte, bad sum
		send_bytes('{HEADER_RESET, 8'h7F, 8'h01, 8'h12, 8'h34});
		random_phase(60, 60, 1'b0, 1'b0);

		// Lowest header and a gap limit of one. One tick is within the limit, two
		// time out mid-frame and the next header byte starts over.
		configure(8'h00, 16'd1);
		send_bytes('{8'h00, 8'h01, 8'h03});
		send_item(KIND_TICK, 8'h5A);
		send_item(KIND_BYTE, 8'h05);
		send_item(KIND_TICK, 8'hC3);
		send_item(KIND_TICK, 8'h3C);
		send_bytes('{8'h00, 8'h80, 8'h00, 8'h00});
		random_phase(60, 60, 1'b0, 1'b1);

		// Highest header and gap limit. Long receiver hold-off while the
		// sender streams frames back to back, then the longest frame.
		configure(8'hFF, 16'hFFFF);
		sender_quiet = 1'b1;
		holds_requested++;
		repeat (2) send_frame(30, 60);
		sender_quiet = 1'b0;
		send_frame(255, 255);
		random_phase(30, 60, 1'b0, 1'b0);

		// Gap limit zero: any tick between two bytes restarts the hunt
		configure(8'($urandom), 16'd0);
		random_phase(60, 40, 1'b0, 1'b0);

		// Idle gap mid-payload: one tick over a modest limit drops the frame,
		// the same gap under the top limit keeps it going
		configure(8'hA5, 16'(TICK_BURST - 1));
		send_bytes('{8'hA5, 8'h03, 8'h02, 8'h10, 8'h08});
		sender_quiet = 1'b1;
		repeat (TICK_BURST) send_item(KIND_TICK, 8'($urandom));
		sender_quiet = 1'b0;
		send_bytes('{8'hA5, 8'h04, 8'h00, 8'h00});
		configure(8'hA5, 16'hFFFF);
		send_bytes('{8'hA5, 8'h05, 8'h02, 8'h10, 8'h08});
		sender_quiet = 1'b1;
		repeat (TICK_BURST) send_item(KIND_TICK, 8'($urandom));
		sender_quiet = 1'b0;
		send_bytes('{8'h08});

		// Random settings, small or large gap limits
		repeat (3) begin
			configure(8'($urandom), ($urandom_range(0, 1) == 1) ?
				16'($urandom_range(1, 40)) : 16'($urandom_range(41, 65535)));
			random_phase(50, 60, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
		end

		settle();
		repeat (20) @(posedge clk);
		if (frames.pending_results.size() == 0 && frames.failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/ufd_pkg.sv
hw/rtl/ufd_regs.sv
hw/rtl/ufd_core.sv
hw/rtl/uart_frame_deframer_checksum_unit.sv
bench/tb_top.sv
